// ===== sv/tpf_pkg.sv =====
package tpf_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int LEVELS    = 3;
  localparam int ID_W      = 32;
  localparam int LV_W      = 2;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE
  } ctrl_state_t;

  typedef struct packed {
    logic                   action;
    logic signed [ID_W-1:0] task_id;
    logic [LV_W-1:0]        priority_req;
  } in_t;

  typedef struct packed {
    logic signed [ID_W-1:0] task_out;
    logic [LV_W-1:0]        level_served;
    logic [1:0]             status;
    logic                   all_empty;
  } out_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage

// ===== sv/tpf_ctrl.sv =====
module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/tpf_datapath.sv =====
module tpf_datapath
  import tpf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  in_t  in_data,
  output out_t out_data
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MEM_D  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];
  logic [IDX_W-1:0] head_nxt [LEVELS];
  logic [IDX_W-1:0] tail_nxt [LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [LEVELS];

  logic [ID_W-1:0]  mem [MEM_D];
  logic [ID_W-1:0]  rdata_r;

  logic [LV_W-1:0]   sel_lv;
  logic              do_push, do_pop;
  logic [1:0]        st;
  logic [LV_W-1:0]   served;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] base, addr;
  logic              none_left;

  logic [LV_W-1:0]   served_r;
  logic [1:0]        status_r;
  logic              all_empty_r;
  logic              popped_r;
  out_t              out_r;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    sel_lv  = '0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    st      = ST_OK;
    served  = '0;
    if (in_data.action == ACT_ENQ) begin
      if (in_data.priority_req == '0) begin
        st = ST_BAD;
      end else begin
        sel_lv = in_data.priority_req - LV_W'(1);
        if (cnt_r[sel_lv] == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
    end else begin
      if (cnt_r[2] != '0) begin
        sel_lv = LV_W'(2);
        do_pop = 1'b1;
      end else if (cnt_r[1] != '0) begin
        sel_lv = LV_W'(1);
        do_pop = 1'b1;
      end else if (cnt_r[0] != '0) begin
        sel_lv = LV_W'(0);
        do_pop = 1'b1;
      end else begin
        st = ST_EMPTY;
      end
      if (do_pop) begin
        served = sel_lv + LV_W'(1);
      end
    end

    idx = do_push ? tail_r[sel_lv] : head_r[sel_lv];
    case (sel_lv)
      2'd1:    base = ADDR_W'(DEPTH);
      2'd2:    base = ADDR_W'(2 * DEPTH);
      default: base = '0;
    endcase
    addr = base + ADDR_W'(idx);

    for (int l = 0; l < LEVELS; l++) begin
      head_nxt[l] = head_r[l];
      tail_nxt[l] = tail_r[l];
      cnt_nxt[l]  = cnt_r[l];
      if (sel_lv == LV_W'(l)) begin
        if (do_push) begin
          tail_nxt[l] = step_idx(tail_r[l]);
          cnt_nxt[l]  = cnt_r[l] + CNT_W'(1);
        end
        if (do_pop) begin
          head_nxt[l] = step_idx(head_r[l]);
          cnt_nxt[l]  = cnt_r[l] - CNT_W'(1);
        end
      end
    end
    none_left = (cnt_nxt[0] == '0) && (cnt_nxt[1] == '0) && (cnt_nxt[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (cmd.accept) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= head_nxt[l];
        tail_r[l] <= tail_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && do_push) begin
      mem[addr] <= in_data.task_id;
    end
    if (cmd.accept) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      served_r    <= served;
      status_r    <= st;
      all_empty_r <= none_left;
      popped_r    <= do_pop;
    end
    if (cmd.load_out) begin
      out_r.task_out     <= popped_r ? rdata_r : '0;
      out_r.level_served <= served_r;
      out_r.status       <= status_r;
      out_r.all_empty    <= all_empty_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/three_level_priority_fifo.sv =====
// Strict-priority task queue with three levels of DEPTH entries each: an enqueue
// beat appends task_id to the FIFO of priority_req (1 lowest, 3 highest), a
// dequeue beat returns the oldest id of the highest non-empty level, and every
// beat yields one result beat with a status (ok, level full, queue empty, bad
// priority) and an all_empty flag. The accepting edge updates the level
// pointers and registers the single-port entry memory read; the output
// register is loaded in S_RESOLVE once it is empty or its result is taken.
// The block takes no new item until the last result is in the output
// register; a new item is accepted while an earlier result still waits to
// be taken, and its own result is held back until that one leaves.
module three_level_priority_fifo
  import tpf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;

  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tpf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
